// ----- rtl/kmss_pkg.sv -----
// kmss_pkg: shared constants, types and helpers for k_maximum_subarray_sums
// used by kmss_ctrl, kmss_dp and the top level; depends on nothing else

package kmss_pkg;

    // list depth and derived widths
    localparam int K_MAX  = 16;
    localparam int IDX_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CNT_W  = $clog2(K_MAX + 1);

    // fixed field widths
    localparam int SUM_W  = 32;
    localparam int ELEM_W = 16;
    localparam int CFG_W  = 5;
    localparam int RANK_W = 4;

    // count_wanted after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_FINISH,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // take the input word, update prefix, trim counts
        logic diff;     // form one candidate from the current small prefix
        logic finish;   // insert the new prefix into the small list
        logic emit;     // load one result into the output register
        logic clear;    // return lists and prefix to their reset values
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic diff_last;  // current small prefix is the last kept one
        logic last_item;  // the word in work carries end_of_array
        logic emit_last;  // current result is the final kept sum
        logic out_free;   // output register can take a new word
    } t_status;

    // clamp a 33-bit signed value to the 32-bit range
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        if (v[SUM_W] != v[SUM_W-1]) begin
            r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/kmss_ctrl.sv -----
// kmss_ctrl: sequencer for k_maximum_subarray_sums
// drives kmss_dp through kmss_pkg::t_cmd, reads kmss_pkg::t_status

module kmss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  kmss_pkg::t_status  i_status,
    output kmss_pkg::t_cmd     o_cmd,
    output logic               o_in_stall
);

    kmss_pkg::t_state r_state;
    kmss_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kmss_pkg::S_IDLE: begin
                if (i_in_valid) n_state = kmss_pkg::S_DIFF;
            end
            kmss_pkg::S_DIFF: begin
                if (i_status.diff_last) n_state = kmss_pkg::S_FINISH;
            end
            kmss_pkg::S_FINISH: begin
                n_state = i_status.last_item ? kmss_pkg::S_EMIT : kmss_pkg::S_IDLE;
            end
            kmss_pkg::S_EMIT: begin
                if (i_status.out_free && i_status.emit_last) n_state = kmss_pkg::S_IDLE;
            end
            default: begin
                n_state = kmss_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            kmss_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            kmss_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
            end
            kmss_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            kmss_pkg::S_EMIT: begin
                o_cmd.emit  = i_status.out_free;
                o_cmd.clear = i_status.out_free && i_status.emit_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/kmss_dp.sv -----
// kmss_dp: prefix sum, sorted small-prefix and top-sum lists, output register
// uses kmss_pkg; commanded by kmss_ctrl

module kmss_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  kmss_pkg::t_cmd                          i_cmd,
    output kmss_pkg::t_status                       o_status,
    input  logic                                    i_cfg_wr_en,
    input  logic [kmss_pkg::CFG_W-1:0]              i_cfg_wr_data,
    input  logic signed [kmss_pkg::ELEM_W-1:0]      i_element,
    input  logic                                    i_end_of_array,
    input  logic                                    i_out_stall,
    output logic                                    o_out_valid,
    output logic signed [kmss_pkg::SUM_W-1:0]       o_sum,
    output logic [kmss_pkg::RANK_W-1:0]             o_rank,
    output logic                                    o_last_of_run
);

    localparam int KM = kmss_pkg::K_MAX;
    localparam int SW = kmss_pkg::SUM_W;
    localparam int CW = kmss_pkg::CNT_W;
    localparam int IW = kmss_pkg::IDX_W;
    localparam int EW = kmss_pkg::ELEM_W;

    logic [kmss_pkg::CFG_W-1:0] r_cfg;
    logic signed [SW-1:0]       r_prefix;
    logic signed [SW-1:0]       r_small [KM];
    logic signed [SW-1:0]       r_top   [KM];
    logic [CW-1:0]              r_scount;
    logic [CW-1:0]              r_tcount;
    logic [IW-1:0]              r_idx;
    logic [IW-1:0]              r_eidx;
    logic signed [SW-1:0]       r_cand;
    logic                       r_cvld;
    logic                       r_last;
    logic                       r_out_vld;
    logic signed [SW-1:0]       r_out_sum;
    logic [kmss_pkg::RANK_W-1:0] r_out_rank;
    logic                       r_out_last;

    logic [CW-1:0]              k;
    logic [IW-1:0]              k_top_idx;
    logic signed [SW-1:0]       n_prefix;
    logic signed [SW-1:0]       n_cand;
    logic [KM-1:0]              top_ge;
    logic [KM-1:0]              small_le;
    logic signed [SW-1:0]       n_top   [KM];
    logic signed [SW-1:0]       n_small [KM];
    logic [CW-1:0]              n_tcount;
    logic [CW-1:0]              n_scount;
    logic                       top_ok;
    logic                       small_ok;

    // effective k: zero acts as one, large values clamp to the depth
    always_comb begin
        if (r_cfg == '0) begin
            k = CW'(1);
        end else if (32'(r_cfg) > 32'(KM)) begin
            k = CW'(KM);
        end else begin
            k = CW'(r_cfg);
        end
        k_top_idx = IW'(k - CW'(1));
    end

    // prefix update and candidate difference, both saturating
    always_comb begin
        n_prefix = kmss_pkg::sat_sum({r_prefix[SW-1], r_prefix}
                                     + {{(SW+1-EW){i_element[EW-1]}}, i_element});
        n_cand   = kmss_pkg::sat_sum({r_prefix[SW-1], r_prefix}
                                     - {r_small[r_idx][SW-1], r_small[r_idx]});
    end

    // top list: insert r_cand into descending order, all entries compared at once
    always_comb begin
        for (int i = 0; i < KM; i++) begin
            top_ge[i] = (CW'(i) < r_tcount) && (r_top[i] >= r_cand);
        end
        top_ok = !top_ge[k_top_idx];
        for (int i = 0; i < KM; i++) begin
            if (top_ge[i]) begin
                n_top[i] = r_top[i];
            end else if (i == 0) begin
                n_top[i] = r_cand;
            end else if (top_ge[i-1]) begin
                n_top[i] = r_cand;
            end else begin
                n_top[i] = r_top[i-1];
            end
        end
        n_tcount = (top_ok && (r_tcount < k)) ? r_tcount + CW'(1) : r_tcount;
    end

    // small list: insert r_prefix into ascending order
    always_comb begin
        for (int i = 0; i < KM; i++) begin
            small_le[i] = (CW'(i) < r_scount) && (r_small[i] <= r_prefix);
        end
        small_ok = !small_le[k_top_idx];
        for (int i = 0; i < KM; i++) begin
            if (small_le[i]) begin
                n_small[i] = r_small[i];
            end else if (i == 0) begin
                n_small[i] = r_prefix;
            end else if (small_le[i-1]) begin
                n_small[i] = r_prefix;
            end else begin
                n_small[i] = r_small[i-1];
            end
        end
        n_scount = (small_ok && (r_scount < k)) ? r_scount + CW'(1) : r_scount;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= kmss_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // prefix, counts and list contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_prefix   <= '0;
            r_small[0] <= '0;
            r_scount   <= CW'(1);
            r_tcount   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prefix <= n_prefix;
                r_scount <= (r_scount > k) ? k : r_scount;
                r_tcount <= (r_tcount > k) ? k : r_tcount;
            end
            if (r_cvld && top_ok) begin
                r_top    <= n_top;
                r_tcount <= n_tcount;
            end
            if (i_cmd.finish && small_ok) begin
                r_small  <= n_small;
                r_scount <= n_scount;
            end
        end
    end

    // candidate stage and walk indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= 1'b0;
            r_idx  <= '0;
            r_eidx <= '0;
            r_last <= 1'b0;
        end else begin
            r_cvld <= i_cmd.diff;
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_eidx <= '0;
                r_last <= i_end_of_array;
            end
            if (i_cmd.diff) begin
                r_cand <= n_cand;
                r_idx  <= r_idx + IW'(1);
            end
            if (i_cmd.emit) begin
                r_eidx <= r_eidx + IW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sum  <= r_top[r_eidx];
            r_out_rank <= kmss_pkg::RANK_W'(r_eidx);
            r_out_last <= o_status.emit_last;
        end
    end

    // status back to the sequencer
    always_comb begin
        o_status.diff_last = (CW'(r_idx) + CW'(1)) == r_scount;
        o_status.last_item = r_last;
        o_status.emit_last = (CW'(r_eidx) + CW'(1)) == r_tcount;
        o_status.out_free  = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid   = r_out_vld;
    assign o_sum         = r_out_sum;
    assign o_rank        = r_out_rank;
    assign o_last_of_run = r_out_last;

endmodule

// ----- rtl/k_maximum_subarray_sums.sv -----
// k_maximum_subarray_sums: k largest contiguous subarray sums over a stream
// per element: a load, then n candidate subtracts at one per cycle, n = kept small
//   prefixes (1..k), then a finish step; each candidate gets a parallel top-list insert
// the input is stalled until the element is finished; on the last element
//   the kept sums follow, one word per cycle while the output is not stalled,
//   and the input stays stalled until the final sum is loaded for output
// reset: synchronous active low, clears lists and prefix, count_wanted back to 4

module k_maximum_subarray_sums (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [kmss_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [kmss_pkg::ELEM_W-1:0]  i_element,
    input  logic                                i_end_of_array,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [kmss_pkg::SUM_W-1:0]   o_sum,
    output logic [kmss_pkg::RANK_W-1:0]         o_rank,
    output logic                                o_last_of_run
);

    kmss_pkg::t_cmd    cmd;
    kmss_pkg::t_status status;

    // sequencer
    kmss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // lists and arithmetic
    kmss_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_element      (i_element),
        .i_end_of_array (i_end_of_array),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_sum          (o_sum),
        .o_rank         (o_rank),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- dv/kmss_sum_checker.sv -----
// kmss_sum_checker: watches the element, result and count_wanted ports of
// k_maximum_subarray_sums, predicts the reported sums and compares them
// depends on kmss_pkg for widths and the count_wanted reset value
`timescale 1ns / 1ps

module kmss_sum_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [kmss_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [kmss_pkg::ELEM_W-1:0]  i_element,
    input  logic                                i_end_of_array,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [kmss_pkg::SUM_W-1:0]   i_sum,
    input  logic [kmss_pkg::RANK_W-1:0]         i_rank,
    input  logic                                i_last_of_run,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int SUM_W  = kmss_pkg::SUM_W;
    localparam int K_MAX  = kmss_pkg::K_MAX;
    localparam int RANK_W = kmss_pkg::RANK_W;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [RANK_W-1:0] rank;
        logic              last;
    } t_sum_word;

    // predicted block state
    logic [kmss_pkg::CFG_W-1:0] k_reg;
    logic signed [SUM_W-1:0]    prefix_acc;
    logic signed [SUM_W-1:0]    low_prefix [K_MAX];
    int                         low_cnt;
    logic signed [SUM_W-1:0]    best_sums [K_MAX];
    int                         best_cnt;

    t_sum_word sums_due [$];
    int        fails = 0;

    function automatic logic signed [SUM_W-1:0] clamp_sum(input longint v);
        longint c;
        c = v;
        if (c > SUM_HI) c = SUM_HI;
        if (c < SUM_LO) c = SUM_LO;
        return c[SUM_W-1:0];
    endfunction

    function automatic void restart_model();
        prefix_acc = '0;
        for (int i = 0; i < K_MAX; i++) begin
            low_prefix[i] = '0;
            best_sums[i]  = '0;
        end
        low_cnt  = 1;
        best_cnt = 0;
    endfunction

    // descending list of kept subarray sums, ties kept
    function automatic void insert_best(input logic signed [SUM_W-1:0] v, input int kk);
        int pos;
        pos = 0;
        while (pos < best_cnt && best_sums[pos] >= v) pos++;
        if (pos < kk) begin
            if (best_cnt < kk) best_cnt++;
            for (int i = best_cnt - 1; i > pos; i--) best_sums[i] = best_sums[i-1];
            best_sums[pos] = v;
        end
    endfunction

    // ascending list of the smallest prefixes seen
    function automatic void insert_low(input logic signed [SUM_W-1:0] v, input int kk);
        int pos;
        pos = 0;
        while (pos < low_cnt && low_prefix[pos] <= v) pos++;
        if (pos < kk) begin
            if (low_cnt < kk) low_cnt++;
            for (int i = low_cnt - 1; i > pos; i--) low_prefix[i] = low_prefix[i-1];
            low_prefix[pos] = v;
        end
    endfunction

    // one accepted element: merge candidates, then report on the last one
    function automatic void fold_element(input logic signed [kmss_pkg::ELEM_W-1:0] elem,
                                         input logic last);
        int        kk;
        t_sum_word w;
        kk = int'(k_reg);
        if (kk < 1) kk = 1;
        if (kk > K_MAX) kk = K_MAX;
        if (low_cnt > kk) low_cnt = kk;
        if (best_cnt > kk) best_cnt = kk;
        prefix_acc = clamp_sum(longint'(prefix_acc) + longint'(elem));
        for (int i = 0; i < low_cnt; i++)
            insert_best(clamp_sum(longint'(prefix_acc) - longint'(low_prefix[i])), kk);
        insert_low(prefix_acc, kk);
        if (last) begin
            for (int i = 0; i < best_cnt; i++) begin
                w.sum  = best_sums[i];
                w.rank = i[RANK_W-1:0];
                w.last = (i == best_cnt - 1);
                sums_due.insert(sums_due.size(), w);
            end
            restart_model();
        end
    endfunction

    // compare one result word with the oldest prediction
    function automatic void check_word();
        t_sum_word want;
        if (sums_due.size() == 0) begin
            fails++;
            $display("%0t: unexpected result word: expected none, got sum=%0d rank=%0d last=%0b",
                     $time, i_sum, i_rank, i_last_of_run);
        end else begin
            want = sums_due.pop_front();
            if (want.sum !== i_sum) begin
                fails++;
                $display("%0t: sum mismatch: expected %0d, got %0d",
                         $time, $signed(want.sum), i_sum);
            end
            if (want.rank !== i_rank) begin
                fails++;
                $display("%0t: rank mismatch: expected %0d, got %0d",
                         $time, want.rank, i_rank);
            end
            if (want.last !== i_last_of_run) begin
                fails++;
                $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                         $time, want.last, i_last_of_run);
            end
        end
    endfunction

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            k_reg = kmss_pkg::CFG_RESET;
            restart_model();
            sums_due.delete();
            fails = 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_word();
            if (i_cfg_wr_en) k_reg = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) fold_element(i_element, i_end_of_array);
        end
        o_pending    <= sums_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- dv/tb_top.sv -----
// tb_top: stimulus, stall generation and verdict for k_maximum_subarray_sums
// depends on kmss_pkg, the block itself and kmss_sum_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int ELEM_W = kmss_pkg::ELEM_W;
    localparam int CFG_W  = kmss_pkg::CFG_W;
    localparam int SUM_W  = kmss_pkg::SUM_W;
    localparam int RANK_W = kmss_pkg::RANK_W;
    localparam int K_MAX  = kmss_pkg::K_MAX;

    localparam int RANDOM_ITEMS   = 130;
    localparam int SETTLE_CYCLES  = K_MAX + 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0]           i_cfg_wr_data  = '0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_stall;
    logic signed [ELEM_W-1:0]   i_element      = '0;
    logic                       i_end_of_array = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall    = 1'b0;
    logic signed [SUM_W-1:0]    o_sum;
    logic [RANK_W-1:0]          o_rank;
    logic                       o_last_of_run;

    int fail_count;
    int pending;

    // steady and hold_req are shared between stimulus and the stall process
    bit steady   = 1'b0;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    k_maximum_subarray_sums u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_element      (i_element),
        .i_end_of_array (i_end_of_array),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sum          (o_sum),
        .o_rank         (o_rank),
        .o_last_of_run  (o_last_of_run)
    );

    kmss_sum_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_element      (i_element),
        .i_end_of_array (i_end_of_array),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_sum          (o_sum),
        .i_rank         (o_rank),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // gap lengths: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // count_wanted values with extra weight on the edges and out-of-range codes
    function automatic logic [CFG_W-1:0] pick_k();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return CFG_W'($urandom_range(K_MAX + 1, (1 << CFG_W) - 1));
        if (r == 2) return CFG_W'(1);
        if (r == 3) return CFG_W'(K_MAX);
        return CFG_W'($urandom_range(1, K_MAX));
    endfunction

    // element values: extremes, a narrow band for ties, and full range
    function automatic logic signed [ELEM_W-1:0] pick_element();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return ELEM_MAX;
        if (r == 1) return ELEM_MIN;
        if (r < 6) return ELEM_W'($urandom_range(0, 40) - 20);
        return ELEM_W'($urandom);
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(input logic signed [ELEM_W-1:0] elem, input logic last);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_element      <= elem;
        i_end_of_array <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // stop offering, let every predicted word drain, then let the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_k(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // receiver stall: random runs, or one long hold on request
    initial begin : out_stall_gen
        int   run_left;
        logic stall_val;
        run_left  = 0;
        stall_val = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                stall_val = 1'b1;
                run_left  = LONG_HOLD;
            end else if (run_left > 0) begin
                run_left--;
            end else if (steady) begin
                stall_val = 1'b0;
            end else begin
                stall_val = ($urandom_range(0, 9) < 3);
                run_left  = pick_gap();
            end
            i_out_stall <= stall_val;
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("k_maximum_subarray_sums regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default k of four after reset
        send_word(16'sd5, 1'b0);
        send_word(-16'sd3, 1'b0);
        send_word(16'sd7, 1'b1);
        // single-element arrays at both extremes
        send_word(ELEM_MAX, 1'b1);
        send_word(ELEM_MIN, 1'b1);
        // equal elements give tied sums
        send_word(16'sd1, 1'b0);
        send_word(16'sd1, 1'b0);
        send_word(16'sd1, 1'b1);
        // largest k, fewer subarrays than k
        write_k(CFG_W'(K_MAX));
        send_word(16'sd3, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sd4, 1'b1);
        // zero acts as one
        write_k('0);
        send_word(-16'sd5, 1'b0);
        send_word(16'sd10, 1'b1);
        // all ones acts as K_MAX
        write_k('1);
        send_word(16'sd1, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sd2, 1'b0);
        send_word(-16'sd2, 1'b0);
        send_word(16'sd3, 1'b1);
        // k shrinks in the middle of an array
        write_k(CFG_W'(4));
        send_word(16'sd4, 1'b0);
        send_word(-16'sd2, 1'b0);
        send_word(16'sd6, 1'b0);
        write_k(CFG_W'(2));
        send_word(16'sd3, 1'b0);
        send_word(-16'sd1, 1'b1);

        // random arrays, some with a k change part way through
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) write_k(pick_k());
            steady = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                if (j == len / 2 && len > 3 && $urandom_range(0, 7) == 0) write_k(pick_k());
                send_word(pick_element(), j == len - 1);
            end
        end

        // receiver holds off while short arrays keep coming
        write_k(CFG_W'(K_MAX));
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (10) begin
            len = $urandom_range(1, 2);
            for (int j = 0; j < len; j++) send_word(pick_element(), j == len - 1);
        end
        steady = 1'b0;

        wait_drained();
        if (fail_count == 0) begin
            $display("k_maximum_subarray_sums regression: pass");
        end else begin
            $display("k_maximum_subarray_sums regression: fail");
        end
        $finish;
    end

endmodule

// ----- k_maximum_subarray_sums.f -----
rtl/kmss_pkg.sv
rtl/kmss_ctrl.sv
rtl/kmss_dp.sv
rtl/k_maximum_subarray_sums.sv
dv/kmss_sum_checker.sv
dv/tb_top.sv
